@@ rtl/core/mgc_pkg.sv @@
`default_nettype none
package mgc_pkg;
  localparam int NomW = 14;
  localparam int AxW = 16;
  localparam int AvgW = 16;
  localparam logic [NomW-1:0] NomXReset = 14'd10112;
  localparam logic [NomW-1:0] NomYReset = 14'd10112;
  localparam logic [NomW-1:0] NomZReset = 14'd9416;
  localparam logic signed [AxW-1:0] AxisMin = -16'sd2048;
  localparam logic signed [AxW-1:0] AxisMax = 16'sd2047;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_SELFTEST = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_CALFAULT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_NOM_X = 2'd0,
    REG_NOM_Y = 2'd1,
    REG_NOM_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic ewma;
    logic load;
    logic step;
    logic store;
    logic [1:0] axis;
    logic finish;
    logic publish;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic fault;
    logic is_st;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/core/mgc_ctrl.sv @@
`default_nettype none
module mgc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output mgc_pkg::cmd_t      cmd,
  input  wire mgc_pkg::sts_t sts
);
  mgc_pkg::state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mgc_pkg::S_IDLE;
      axis_r <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt = axis_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.axis = axis_r;
    cmd.status = mgc_pkg::ST_VALID;
    in_tready = 1'b0;
    // result held in the output register until its transfer
    out_tvalid = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      mgc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tready) begin
          cmd.capture = 1'b1;
          state_nxt = mgc_pkg::S_CHECK;
        end
      end
      mgc_pkg::S_CHECK: begin
        state_nxt = mgc_pkg::S_OUT;
        if (sts.ovf) cmd.status = mgc_pkg::ST_OVERFLOW;
        else if (sts.is_st) begin
          cmd.ewma = 1'b1;
          cmd.status = mgc_pkg::ST_SELFTEST;
        end else if (sts.fault) cmd.status = mgc_pkg::ST_CALFAULT;
        else begin
          axis_nxt = 2'd0;
          state_nxt = mgc_pkg::S_LOAD;
        end
        if (state_nxt == mgc_pkg::S_OUT) cmd.finish = 1'b1;
      end
      mgc_pkg::S_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = mgc_pkg::S_DIV;
      end
      mgc_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) state_nxt = mgc_pkg::S_STORE;
      end
      mgc_pkg::S_STORE: begin
        cmd.store = 1'b1;
        if (axis_r == 2'd2) begin
          cmd.finish = 1'b1;
          state_nxt = mgc_pkg::S_OUT;
        end else begin
          axis_nxt = axis_r + 2'd1;
          state_nxt = mgc_pkg::S_LOAD;
        end
      end
      mgc_pkg::S_OUT: begin
        if (!ov_r || out_tready) begin
          cmd.publish = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = mgc_pkg::S_IDLE;
        end
      end
      default: state_nxt = mgc_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/mgc_dp.sv @@
`default_nettype none
module mgc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [mgc_pkg::NomW-1:0]        cfg_data,
  input  wire logic                            in_type,
  input  wire logic [3*mgc_pkg::AxW-1:0]       in_raw,
  input  wire mgc_pkg::cmd_t                   cmd,
  output mgc_pkg::sts_t                        sts,
  output logic [3*mgc_pkg::AxW+1:0]            out_data
);
  localparam int AW = mgc_pkg::AxW;
  localparam int VW = mgc_pkg::AvgW;
  localparam int PW = 30; // |m*nom| < 2^25, magnitude width
  logic [mgc_pkg::NomW-1:0] nom_r [3];
  logic signed [mgc_pkg::AvgW-1:0] avg_r [3];
  logic signed [AW-1:0] raw_r [3];
  logic type_r;
  logic signed [AW-1:0] res_r [3];
  mgc_pkg::status_t st_r;
  logic [3*AW+1:0] out_r;
  logic [PW-1:0] rem_r, quo_r;
  logic [PW-1:0] num_mag;
  logic [15:0] div_r;
  logic neg_r;
  logic [4:0] cnt_r;
  logic signed [AW-1:0] mx;
  logic signed [mgc_pkg::AvgW-1:0] tx;
  logic signed [PW:0] prod;
  logic [PW:0] trial;
  logic [PW-1:0] rem_sh;

  // raw_r index: 0 x, 1 y, 2 z (device order x,z,y unpacked at capture)
  always_comb begin
    sts.ovf = 1'b0;
    sts.fault = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (raw_r[i] < mgc_pkg::AxisMin || raw_r[i] > mgc_pkg::AxisMax) sts.ovf = 1'b1;
      if (avg_r[i] <= 0) sts.fault = 1'b1;
    end
    sts.is_st = type_r;
    sts.div_done = (cnt_r == 5'd0);
  end

  assign mx = raw_r[cmd.axis];
  assign tx = avg_r[cmd.axis];
  assign prod = (PW+1)'(mx) * $signed({1'b0, nom_r[cmd.axis]});
  assign num_mag = prod[PW] ? PW'(-prod) : prod[PW-1:0];
  assign rem_sh = {rem_r[PW-2:0], quo_r[PW-1]};
  assign trial = {1'b0, rem_sh} - {15'd0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r[0] <= mgc_pkg::NomXReset;
      nom_r[1] <= mgc_pkg::NomYReset;
      nom_r[2] <= mgc_pkg::NomZReset;
      avg_r[0] <= 16'(mgc_pkg::NomXReset);
      avg_r[1] <= 16'(mgc_pkg::NomYReset);
      avg_r[2] <= 16'(mgc_pkg::NomZReset);
      cnt_r <= 5'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mgc_pkg::REG_NOM_X: nom_r[0] <= cfg_data;
          mgc_pkg::REG_NOM_Y: nom_r[1] <= cfg_data;
          mgc_pkg::REG_NOM_Z: nom_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ewma) begin
        for (int i = 0; i < 3; i++)
          avg_r[i] <= VW'(int'(avg_r[i]) - (int'(avg_r[i]) * 2) / 8 + int'(raw_r[i]) * 2);
      end
      if (cmd.load) cnt_r <= 5'(PW);
      else if (cmd.step && cnt_r != 5'd0) cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= in_type;
      raw_r[0] <= in_raw[AW-1:0];
      raw_r[2] <= in_raw[2*AW-1:AW];
      raw_r[1] <= in_raw[3*AW-1:2*AW];
      for (int i = 0; i < 3; i++) res_r[i] <= '0;
    end
    if (cmd.load) begin
      quo_r <= num_mag;
      rem_r <= '0;
      div_r <= tx;
      neg_r <= prod[PW];
    end else if (cmd.step && cnt_r != 5'd0) begin
      if (!trial[PW]) begin
        rem_r <= trial[PW-1:0];
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.store) begin
      if (neg_r) res_r[cmd.axis] <= (quo_r > PW'(32768)) ? -16'sd32768 : AW'(-quo_r);
      else res_r[cmd.axis] <= (quo_r > PW'(32767)) ? 16'sd32767 : AW'(quo_r);
    end
    if (cmd.finish) st_r <= cmd.status;
    if (cmd.publish) out_r <= {st_r, res_r[2], res_r[1], res_r[0]};
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

@@ rtl/core/magnetometer_gain_compensation.sv @@
`default_nettype none
// Three-axis magnetometer gain compensation. A measurement runs one shared
// 30-step restoring divider per axis in turn; a self-test, overflow or
// calibration-fault item skips it. A new input is taken only from idle. A
// finished result waits in an output register, so the next item proceeds
// while it is held. The user must write the nominal registers through the
// cfg port only while idle; the block itself does not enforce it.
module magnetometer_gain_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // raw_x, raw_z, raw_y
  input  wire logic        in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // field_x, field_y, field_z
  output logic [1:0]       out_tuser  // status
);
  mgc_pkg::cmd_t cmd;
  mgc_pkg::sts_t sts;
  logic [49:0] od;

  assign cfg_ready = 1'b1;

  mgc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts
  );

  mgc_dp u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index,
    .cfg_data(cfg_data[mgc_pkg::NomW-1:0]),
    .in_type(in_tuser), .in_raw(in_tdata), .cmd, .sts, .out_data(od)
  );

  assign out_tdata = od[47:0];
  assign out_tuser = od[49:48];
endmodule
`default_nettype wire
